// ----- rtl/core/qun_pkg.sv -----
package qun_pkg;

  localparam int COORD_WIDTH      = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORM_BITS        = 30;

  localparam int EDGE_W       = COORD_WIDTH + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int SUM_W        = PROD_W + 2;
  localparam int LEN_W        = $clog2(SUM_W + 1);
  localparam int SHIFT_W      = SUM_W + NORM_BITS;
  localparam int SQ_W         = 2 * NORM_BITS;
  localparam int Q_W          = SQ_W + 2;
  localparam int ROOT_W       = Q_W / 2;
  localparam int REM_W        = ROOT_W + 2;
  localparam int QUO_W        = NORMAL_FRAC_BITS + 1;
  localparam int NUM_W        = NORM_BITS + NORMAL_FRAC_BITS + 1;
  localparam int DREM_W       = ROOT_W + 1;
  localparam int OUT_W        = NORMAL_FRAC_BITS + 2;
  localparam int FRONT_STAGES = 8;
  localparam int NORMAL_ONE   = 1 << NORMAL_FRAC_BITS;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]      edge_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [SUM_W-1:0]              mag_t;
  typedef logic [LEN_W-1:0]              len_t;
  typedef logic [NORM_BITS-1:0]          mm_t;
  typedef logic [SQ_W-1:0]               sq_t;
  typedef logic [Q_W-1:0]                q_t;
  typedef logic [ROOT_W-1:0]             root_t;
  typedef logic [REM_W-1:0]              rem_t;
  typedef logic [QUO_W-1:0]              quo_t;
  typedef logic [NUM_W-1:0]              num_t;
  typedef logic [DREM_W-1:0]             drem_t;
  typedef logic signed [OUT_W-1:0]       normal_t;

  typedef struct packed {
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
    coord_t p3_x;
    coord_t p3_y;
    coord_t p3_z;
    coord_t p4_x;
    coord_t p4_y;
    coord_t p4_z;
  } in_word_t;

  typedef struct packed {
    normal_t normal_x;
    normal_t normal_y;
    normal_t normal_z;
    logic    degenerate;
  } out_word_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } cvec_t;

  typedef struct packed {
    edge_t x;
    edge_t y;
    edge_t z;
  } evec_t;

  typedef struct packed {
    logic            valid;
    logic [2:0]      neg;
    mm_t [2:0]       mm;
    logic            deg;
    q_t              q;
  } front_t;

  typedef struct packed {
    logic            valid;
    logic [2:0]      neg;
    mm_t [2:0]       mm;
    logic            deg;
    root_t           root;
  } root_out_t;

  typedef struct packed {
    logic            valid;
    logic [2:0]      neg;
    logic            deg;
    quo_t [2:0]      quo;
  } div_out_t;

  function automatic evec_t vec_sub(cvec_t to, cvec_t from);
    evec_t e;
    e.x = edge_t'(to.x) - edge_t'(from.x);
    e.y = edge_t'(to.y) - edge_t'(from.y);
    e.z = edge_t'(to.z) - edge_t'(from.z);
    return e;
  endfunction

  function automatic len_t bit_len(mag_t v);
    len_t n;
    n = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (v[i]) begin
        n = len_t'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic mm_t norm_shift(mag_t v, len_t n);
    logic [SHIFT_W-1:0] t;
    t = SHIFT_W'(v);
    if (int'(n) > NORM_BITS) begin
      t = t >> (int'(n) - NORM_BITS);
    end else begin
      t = t << (NORM_BITS - int'(n));
    end
    return t[NORM_BITS-1:0];
  endfunction

endpackage

// ----- rtl/core/quad_unit_normal_core.sv -----
// Unit face normal of a quad: each input word carries the four corners, and each output
// word the normal of (p2-p1)x(p3-p2) + (p4-p3)x(p1-p4) in signed Q1.14, rounded half away
// from zero, with the degenerate flag set and all components zero when that sum vanishes.
// The pipeline takes one word per clock while in_stall is low and returns the results in
// order: eight stages form the edges, cross products, magnitudes, normalisation and the
// sum of squares, 31 stages take the square root two bits at a time, and 16 stages divide,
// a setup stage and then one quotient bit per stage. A stalled output holds the pipeline
// only once its skid register is full, so words are still taken while the output stalls.
module quad_unit_normal_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qun_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qun_pkg::out_word_t  out_data
);

  logic                en;
  qun_pkg::front_t     front;
  qun_pkg::root_out_t  root;
  qun_pkg::div_out_t   div;
  qun_pkg::out_word_t  res;
  logic                take;

  logic                out_valid_r, out_valid_nxt;
  qun_pkg::out_word_t  out_data_r, out_data_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  qun_pkg::out_word_t  skid_data_r, skid_data_nxt;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign take     = out_valid_r && !out_stall;

  qun_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .front_o  (front)
  );

  qun_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .front_i (front),
    .root_o  (root)
  );

  qun_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .root_i (root),
    .div_o  (div)
  );

  always_comb begin
    res.degenerate = div.deg;
    res.normal_x   = div.neg[0] ? -qun_pkg::normal_t'(div.quo[0]) : qun_pkg::normal_t'(div.quo[0]);
    res.normal_y   = div.neg[1] ? -qun_pkg::normal_t'(div.quo[1]) : qun_pkg::normal_t'(div.quo[1]);
    res.normal_z   = div.neg[2] ? -qun_pkg::normal_t'(div.quo[2]) : qun_pkg::normal_t'(div.quo[2]);
    if (div.deg) begin
      res.normal_x = '0;
      res.normal_y = '0;
      res.normal_z = '0;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else begin
      if (take) begin
        out_valid_nxt = 1'b0;
      end
      if (div.valid) begin
        if (!out_valid_r || take) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
        end else begin
          skid_valid_nxt = 1'b1;
          skid_data_nxt  = res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled while the output was free");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.degenerate) |->
      (out_data_r.normal_x == '0 && out_data_r.normal_y == '0 && out_data_r.normal_z == '0))
    else $error("degenerate word with non-zero components");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_data_r.normal_x <= qun_pkg::NORMAL_ONE && out_data_r.normal_x >= -qun_pkg::NORMAL_ONE
       && out_data_r.normal_y <= qun_pkg::NORMAL_ONE
       && out_data_r.normal_y >= -qun_pkg::NORMAL_ONE
       && out_data_r.normal_z <= qun_pkg::NORMAL_ONE
       && out_data_r.normal_z >= -qun_pkg::NORMAL_ONE))
    else $error("normal component beyond unit range");
`endif

endmodule

// ----- rtl/core/qun_front.sv -----
module qun_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  qun_pkg::in_word_t  in_data,
  output qun_pkg::front_t    front_o
);

  logic [qun_pkg::FRONT_STAGES-1:0] v_r;

  qun_pkg::evec_t ea_r, eb_r, ec_r, ed_r;
  qun_pkg::prod_t p_r [12];
  qun_pkg::sum_t  s_r [3];
  logic [2:0]     neg4_r, neg5_r, neg6_r, neg7_r, neg8_r;
  qun_pkg::mag_t  mag4_r [3];
  qun_pkg::mag_t  mag5_r [3];
  qun_pkg::mag_t  or4_r;
  qun_pkg::len_t  len5_r;
  qun_pkg::mm_t   mm6_r [3];
  qun_pkg::mm_t   mm7_r [3];
  qun_pkg::mm_t   mm8_r [3];
  logic           deg6_r, deg7_r, deg8_r;
  qun_pkg::sq_t   sq7_r [3];
  qun_pkg::q_t    q8_r;

  qun_pkg::cvec_t p1, p2, p3, p4;

  assign p1 = '{x: in_data.p1_x, y: in_data.p1_y, z: in_data.p1_z};
  assign p2 = '{x: in_data.p2_x, y: in_data.p2_y, z: in_data.p2_z};
  assign p3 = '{x: in_data.p3_x, y: in_data.p3_y, z: in_data.p3_z};
  assign p4 = '{x: in_data.p4_x, y: in_data.p4_y, z: in_data.p4_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[qun_pkg::FRONT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea_r <= qun_pkg::vec_sub(p2, p1);
      eb_r <= qun_pkg::vec_sub(p3, p2);
      ec_r <= qun_pkg::vec_sub(p4, p3);
      ed_r <= qun_pkg::vec_sub(p1, p4);

      p_r[0]  <= qun_pkg::prod_t'(ea_r.y) * qun_pkg::prod_t'(eb_r.z);
      p_r[1]  <= qun_pkg::prod_t'(ea_r.z) * qun_pkg::prod_t'(eb_r.y);
      p_r[2]  <= qun_pkg::prod_t'(ec_r.y) * qun_pkg::prod_t'(ed_r.z);
      p_r[3]  <= qun_pkg::prod_t'(ec_r.z) * qun_pkg::prod_t'(ed_r.y);
      p_r[4]  <= qun_pkg::prod_t'(ea_r.z) * qun_pkg::prod_t'(eb_r.x);
      p_r[5]  <= qun_pkg::prod_t'(ea_r.x) * qun_pkg::prod_t'(eb_r.z);
      p_r[6]  <= qun_pkg::prod_t'(ec_r.z) * qun_pkg::prod_t'(ed_r.x);
      p_r[7]  <= qun_pkg::prod_t'(ec_r.x) * qun_pkg::prod_t'(ed_r.z);
      p_r[8]  <= qun_pkg::prod_t'(ea_r.x) * qun_pkg::prod_t'(eb_r.y);
      p_r[9]  <= qun_pkg::prod_t'(ea_r.y) * qun_pkg::prod_t'(eb_r.x);
      p_r[10] <= qun_pkg::prod_t'(ec_r.x) * qun_pkg::prod_t'(ed_r.y);
      p_r[11] <= qun_pkg::prod_t'(ec_r.y) * qun_pkg::prod_t'(ed_r.x);

      for (int i = 0; i < 3; i++) begin
        s_r[i] <= qun_pkg::sum_t'(p_r[4*i]) - qun_pkg::sum_t'(p_r[4*i+1])
                + qun_pkg::sum_t'(p_r[4*i+2]) - qun_pkg::sum_t'(p_r[4*i+3]);
      end

      for (int i = 0; i < 3; i++) begin
        neg4_r[i] <= s_r[i][qun_pkg::SUM_W-1];
        mag4_r[i] <= s_r[i][qun_pkg::SUM_W-1] ? qun_pkg::mag_t'(-s_r[i])
                                              : qun_pkg::mag_t'(s_r[i]);
      end
      or4_r <= (s_r[0][qun_pkg::SUM_W-1] ? qun_pkg::mag_t'(-s_r[0]) : qun_pkg::mag_t'(s_r[0]))
             | (s_r[1][qun_pkg::SUM_W-1] ? qun_pkg::mag_t'(-s_r[1]) : qun_pkg::mag_t'(s_r[1]))
             | (s_r[2][qun_pkg::SUM_W-1] ? qun_pkg::mag_t'(-s_r[2]) : qun_pkg::mag_t'(s_r[2]));

      len5_r <= qun_pkg::bit_len(or4_r);
      neg5_r <= neg4_r;
      for (int i = 0; i < 3; i++) begin
        mag5_r[i] <= mag4_r[i];
      end

      for (int i = 0; i < 3; i++) begin
        mm6_r[i] <= qun_pkg::norm_shift(mag5_r[i], len5_r);
      end
      neg6_r <= neg5_r;
      deg6_r <= (len5_r == '0);

      for (int i = 0; i < 3; i++) begin
        sq7_r[i] <= qun_pkg::sq_t'(mm6_r[i]) * qun_pkg::sq_t'(mm6_r[i]);
        mm7_r[i] <= mm6_r[i];
      end
      neg7_r <= neg6_r;
      deg7_r <= deg6_r;

      q8_r <= qun_pkg::q_t'(sq7_r[0]) + qun_pkg::q_t'(sq7_r[1]) + qun_pkg::q_t'(sq7_r[2]);
      for (int i = 0; i < 3; i++) begin
        mm8_r[i] <= mm7_r[i];
      end
      neg8_r <= neg7_r;
      deg8_r <= deg7_r;
    end
  end

  always_comb begin
    front_o.valid = v_r[qun_pkg::FRONT_STAGES-1];
    front_o.neg   = neg8_r;
    front_o.mm[0] = mm8_r[0];
    front_o.mm[1] = mm8_r[1];
    front_o.mm[2] = mm8_r[2];
    front_o.deg   = deg8_r;
    front_o.q     = q8_r;
  end

endmodule

// ----- rtl/core/qun_isqrt.sv -----
module qun_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  qun_pkg::front_t     front_i,
  output qun_pkg::root_out_t  root_o
);

  typedef struct packed {
    logic [2:0]          neg;
    qun_pkg::mm_t [2:0]  mm;
    logic                deg;
    qun_pkg::q_t         q;
    qun_pkg::rem_t       rem;
    qun_pkg::root_t      root;
  } sqst_t;

  logic [qun_pkg::ROOT_W-1:0] v_r;
  sqst_t                      stg_r [qun_pkg::ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[qun_pkg::ROOT_W-2:0], front_i.valid};
    end
  end

  for (genvar k = 0; k < qun_pkg::ROOT_W; k++) begin : g_stage
    sqst_t          src;
    sqst_t          nxt;
    qun_pkg::rem_t  rem_sh;
    qun_pkg::rem_t  trial;

    if (k == 0) begin : g_first
      always_comb begin
        src.neg  = front_i.neg;
        src.mm   = front_i.mm;
        src.deg  = front_i.deg;
        src.q    = front_i.q;
        src.rem  = '0;
        src.root = '0;
      end
    end else begin : g_next
      assign src = stg_r[k-1];
    end

    always_comb begin
      nxt    = src;
      rem_sh = {src.rem[qun_pkg::REM_W-3:0], src.q[qun_pkg::Q_W-1 -: 2]};
      trial  = {src.root, 2'b01};
      nxt.q  = {src.q[qun_pkg::Q_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        nxt.rem  = rem_sh - trial;
        nxt.root = {src.root[qun_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_sh;
        nxt.root = {src.root[qun_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= nxt;
      end
    end
  end

  always_comb begin
    root_o.valid = v_r[qun_pkg::ROOT_W-1];
    root_o.neg   = stg_r[qun_pkg::ROOT_W-1].neg;
    root_o.mm    = stg_r[qun_pkg::ROOT_W-1].mm;
    root_o.deg   = stg_r[qun_pkg::ROOT_W-1].deg;
    root_o.root  = stg_r[qun_pkg::ROOT_W-1].root;
  end

endmodule

// ----- rtl/core/qun_div.sv -----
module qun_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  qun_pkg::root_out_t  root_i,
  output qun_pkg::div_out_t   div_o
);

  typedef struct packed {
    logic [2:0]            neg;
    logic                  deg;
    qun_pkg::root_t        den;
    qun_pkg::drem_t [2:0]  rem;
    qun_pkg::quo_t [2:0]   nlow;
    qun_pkg::quo_t [2:0]   quo;
  } dvst_t;

  logic [qun_pkg::QUO_W:0] v_r;
  dvst_t                   pre_r;
  dvst_t                   stg_r [qun_pkg::QUO_W];
  qun_pkg::num_t           num [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = qun_pkg::num_t'({root_i.mm[i], {qun_pkg::NORMAL_FRAC_BITS{1'b0}}})
             + qun_pkg::num_t'(root_i.root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[qun_pkg::QUO_W-1:0], root_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r.neg <= root_i.neg;
      pre_r.deg <= root_i.deg;
      pre_r.den <= root_i.root;
      for (int i = 0; i < 3; i++) begin
        pre_r.rem[i]  <= qun_pkg::drem_t'(num[i][qun_pkg::NUM_W-1:qun_pkg::QUO_W]);
        pre_r.nlow[i] <= num[i][qun_pkg::QUO_W-1:0];
        pre_r.quo[i]  <= '0;
      end
    end
  end

  for (genvar k = 0; k < qun_pkg::QUO_W; k++) begin : g_stage
    dvst_t           src;
    dvst_t           nxt;
    qun_pkg::drem_t  rem_sh [3];

    if (k == 0) begin : g_first
      assign src = pre_r;
    end else begin : g_next
      assign src = stg_r[k-1];
    end

    always_comb begin
      nxt = src;
      for (int i = 0; i < 3; i++) begin
        rem_sh[i]   = {src.rem[i][qun_pkg::DREM_W-2:0], src.nlow[i][qun_pkg::QUO_W-1]};
        nxt.nlow[i] = {src.nlow[i][qun_pkg::QUO_W-2:0], 1'b0};
        if (rem_sh[i] >= qun_pkg::drem_t'(src.den)) begin
          nxt.rem[i] = rem_sh[i] - qun_pkg::drem_t'(src.den);
          nxt.quo[i] = {src.quo[i][qun_pkg::QUO_W-2:0], 1'b1};
        end else begin
          nxt.rem[i] = rem_sh[i];
          nxt.quo[i] = {src.quo[i][qun_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= nxt;
      end
    end
  end

  always_comb begin
    div_o.valid = v_r[qun_pkg::QUO_W];
    div_o.neg   = stg_r[qun_pkg::QUO_W-1].neg;
    div_o.deg   = stg_r[qun_pkg::QUO_W-1].deg;
    div_o.quo   = stg_r[qun_pkg::QUO_W-1].quo;
  end

endmodule
